FILE: hw/rtl/lswp_pkg.sv
// Shared constants, types and the divider step for the line position unit.
`timescale 1ns / 1ps
package lswp_pkg;

	localparam int SENSOR_COUNT = 5;
	localparam int SAMPLE_BITS  = 10;
	localparam int WEIGHT_BITS  = 12;

	localparam int TOTAL_BITS = 13;                       // sum of strengths
	localparam int PROD_BITS  = SAMPLE_BITS + 1 + WEIGHT_BITS;
	localparam int WSUM_BITS  = PROD_BITS + 3;            // sum of up to 8 products
	localparam int MAG_BITS   = WSUM_BITS - 1;
	localparam int POS_BITS   = 12;
	localparam int QUO_BITS   = MAG_BITS - TOTAL_BITS;    // quotient bits produced
	localparam int DIV_STEP   = 3;                        // quotient bits per stage

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 64;

	localparam int REG_THR = 0;
	localparam int REG_WGT = 1;
	localparam int REG_MIN = 2;
	localparam int REG_DRK = 3;

	localparam logic signed [POS_BITS:0] POS_MAX = (POS_BITS + 1)'(2047);
	localparam logic signed [POS_BITS:0] POS_MIN = -(POS_BITS + 1)'(2048);

	typedef struct packed {
		logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] thr;
		logic [SENSOR_COUNT-1:0][WEIGHT_BITS-1:0] wgt;
		logic [TOTAL_BITS-1:0]                    min_strength;
		logic                                     dark_is_low;
	} lswp_cfg_t;

	// One in-flight division: partial remainder, dividend bits still to
	// shift in, quotient so far, divisor (the total) and side flags.
	typedef struct packed {
		logic [TOTAL_BITS-1:0] rem;
		logic [QUO_BITS-1:0]   num;
		logic [QUO_BITS-1:0]   quo;
		logic [TOTAL_BITS-1:0] dvs;
		logic                  neg;
		logic                  do_div;
		logic                  seen;
		logic                  all_on;
	} lswp_div_t;

	// Restoring division, DIV_STEP quotient bits.
	function automatic lswp_div_t div_step(lswp_div_t d);
		lswp_div_t         r;
		logic [TOTAL_BITS:0] t;
		r = d;
		for (int k = 0; k < DIV_STEP; k++) begin
			t = {r.rem, r.num[QUO_BITS-1]};
			r.num = {r.num[QUO_BITS-2:0], 1'b0};
			if (t >= {1'b0, r.dvs}) begin
				t = t - {1'b0, r.dvs};
				r.quo = {r.quo[QUO_BITS-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[QUO_BITS-2:0], 1'b0};
			end
			r.rem = t[TOTAL_BITS-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/lswp_cfg.sv
// APB register file: thresholds, weights, minimum strength, polarity.
`timescale 1ns / 1ps
module lswp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lswp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lswp_pkg::DATA_BITS-1:0] pwdata,
	output logic [lswp_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output lswp_pkg::lswp_cfg_t            cfg
);
	localparam int THR_W = lswp_pkg::SENSOR_COUNT * lswp_pkg::SAMPLE_BITS;
	localparam int WGT_W = lswp_pkg::SENSOR_COUNT * lswp_pkg::WEIGHT_BITS;

	logic [THR_W-1:0]                thr_q;
	logic [WGT_W-1:0]                wgt_q;
	logic [lswp_pkg::TOTAL_BITS-1:0] min_q;
	logic                            dark_q;
	logic [1:0]                      idx;
	logic                            wr;

	assign idx    = paddr[4:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			wgt_q  <= '0;
			min_q  <= '0;
			dark_q <= 1'b1;
		end else if (wr) begin
			case (idx)
				2'(lswp_pkg::REG_THR): thr_q  <= pwdata[THR_W-1:0];
				2'(lswp_pkg::REG_WGT): wgt_q  <= pwdata[WGT_W-1:0];
				2'(lswp_pkg::REG_MIN): min_q  <= pwdata[lswp_pkg::TOTAL_BITS-1:0];
				2'(lswp_pkg::REG_DRK): dark_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			2'(lswp_pkg::REG_THR): prdata = lswp_pkg::DATA_BITS'(thr_q);
			2'(lswp_pkg::REG_WGT): prdata = lswp_pkg::DATA_BITS'(wgt_q);
			2'(lswp_pkg::REG_MIN): prdata = lswp_pkg::DATA_BITS'(min_q);
			2'(lswp_pkg::REG_DRK): prdata = lswp_pkg::DATA_BITS'(dark_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.thr          = thr_q;
	assign cfg.wgt          = wgt_q;
	assign cfg.min_strength = min_q;
	assign cfg.dark_is_low  = dark_q;

endmodule

FILE: hw/rtl/lswp_front.sv
// Stages 1-4: strengths, products, sums, sign/magnitude split for the divider.
`timescale 1ns / 1ps
module lswp_front (
	input  logic                                                          clk,
	input  logic                                                          arst_n,
	input  logic                                                          in_valid,
	input  logic [lswp_pkg::SENSOR_COUNT-1:0][lswp_pkg::SAMPLE_BITS-1:0] smp,
	input  lswp_pkg::lswp_cfg_t                                           cfg,
	input  logic [3:0]                                                    adv,
	output logic [3:0]                                                    vld,
	output lswp_pkg::lswp_div_t                                           div_o
);
	localparam int N  = lswp_pkg::SENSOR_COUNT;
	localparam int SB = lswp_pkg::SAMPLE_BITS;
	localparam int TB = lswp_pkg::TOTAL_BITS;
	localparam int PB = lswp_pkg::PROD_BITS;
	localparam int WB = lswp_pkg::WSUM_BITS;
	localparam int MB = lswp_pkg::MAG_BITS;
	localparam int QB = lswp_pkg::QUO_BITS;

	logic [SB:0]           diff [N];
	logic [SB-1:0]         str_d [N];
	logic                  all_on_d;
	logic signed [PB-1:0]  prod_d [N];
	logic [TB-1:0]         tot_d;
	logic signed [WB-1:0]  wsum_d;
	logic [MB-1:0]         mag_d;

	logic [SB-1:0]         str_s1 [N];
	logic                  all_on_s1;
	logic signed [PB-1:0]  prod_s2 [N];
	logic [TB-1:0]         tot_s2;
	logic                  all_on_s2;
	logic signed [WB-1:0]  wsum_s3;
	logic [TB-1:0]         tot_s3;
	logic                  seen_s3;
	logic                  all_on_s3;
	lswp_pkg::lswp_div_t   div_s4;
	logic [3:0]            vld_s;

	// strength per sensor, clamped at zero
	always_comb begin
		all_on_d = 1'b1;
		for (int i = 0; i < N; i++) begin
			if (cfg.dark_is_low)
				diff[i] = {1'b0, cfg.thr[i]} - {1'b0, smp[i]};
			else
				diff[i] = {1'b0, smp[i]} - {1'b0, cfg.thr[i]};
			str_d[i] = diff[i][SB] ? '0 : diff[i][SB-1:0];
			if (str_d[i] == '0)
				all_on_d = 1'b0;
		end
	end

	always_comb begin
		tot_d = '0;
		for (int i = 0; i < N; i++) begin
			prod_d[i] = PB'($signed({1'b0, str_s1[i]}) * $signed(cfg.wgt[i]));
			tot_d     = tot_d + TB'(str_s1[i]);
		end
	end

	always_comb begin
		wsum_d = '0;
		for (int i = 0; i < N; i++)
			wsum_d = wsum_d + WB'(prod_s2[i]);
	end

	assign mag_d = wsum_s3[WB-1] ? MB'(-wsum_s3) : MB'(wsum_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_valid;
			if (adv[1]) vld_s[1] <= vld_s[0];
			if (adv[2]) vld_s[2] <= vld_s[1];
			if (adv[3]) vld_s[3] <= vld_s[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			str_s1    <= str_d;
			all_on_s1 <= all_on_d;
		end
		if (adv[1]) begin
			prod_s2   <= prod_d;
			tot_s2    <= tot_d;
			all_on_s2 <= all_on_s1;
		end
		if (adv[2]) begin
			wsum_s3   <= wsum_d;
			tot_s3    <= tot_s2;
			seen_s3   <= (tot_s2 >= cfg.min_strength);
			all_on_s3 <= all_on_s2;
		end
		if (adv[3]) begin
			div_s4.rem    <= mag_d[MB-1 -: TB];
			div_s4.num    <= mag_d[QB-1:0];
			div_s4.quo    <= '0;
			div_s4.dvs    <= tot_s3;
			div_s4.neg    <= wsum_s3[WB-1];
			div_s4.do_div <= seen_s3 & (tot_s3 != '0);
			div_s4.seen   <= seen_s3;
			div_s4.all_on <= all_on_s3;
		end
	end

	assign vld   = vld_s;
	assign div_o = div_s4;

endmodule

FILE: hw/rtl/lswp_divider.sv
// Stages 5-8: pipelined restoring divider, three quotient bits per stage.
`timescale 1ns / 1ps
module lswp_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  lswp_pkg::lswp_div_t div_i,
	input  logic [3:0]          adv,
	output logic [3:0]          vld,
	output lswp_pkg::lswp_div_t div_o
);
	lswp_pkg::lswp_div_t div_s5;
	lswp_pkg::lswp_div_t div_s6;
	lswp_pkg::lswp_div_t div_s7;
	lswp_pkg::lswp_div_t div_s8;
	logic [3:0]          vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= in_vld;
			if (adv[1]) vld_s[1] <= vld_s[0];
			if (adv[2]) vld_s[2] <= vld_s[1];
			if (adv[3]) vld_s[3] <= vld_s[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) div_s5 <= lswp_pkg::div_step(div_i);
		if (adv[1]) div_s6 <= lswp_pkg::div_step(div_s5);
		if (adv[2]) div_s7 <= lswp_pkg::div_step(div_s6);
		if (adv[3]) div_s8 <= lswp_pkg::div_step(div_s7);
	end

	assign vld   = vld_s;
	assign div_o = div_s8;

endmodule

FILE: hw/rtl/line_sensor_weighted_position_unit.sv
// Top level: weighted-average line position from five line-sensor samples.
`timescale 1ns / 1ps
//
//  channel   signals                              dir   beat
//  --------  -----------------------------------  ----  ----------------------------
//  in        in_valid/in_ready, sample_zero..four  in    one sample set
//  out       out_valid/out_ready, line_position,   out   one position result
//            total_strength, line_seen, all_on_line
//  cfg       psel/penable/pwrite/paddr/pwdata/     in    one 64-bit register access
//            prdata/pready
//
//  One beat per cycle in and out while the output is not stalled.
//  Depth is set by the divider: 12 quotient bits, 3 per stage over 4 stages.
//  arst_n clears all stage valid bits and restores register reset values.
//  Each stage moves when it is empty or the next one moves, so bubbles
//  collapse under an output stall and no beat is dropped or duplicated.
module line_sensor_weighted_position_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [lswp_pkg::SAMPLE_BITS-1:0]      sample_zero,
	input  logic [lswp_pkg::SAMPLE_BITS-1:0]      sample_one,
	input  logic [lswp_pkg::SAMPLE_BITS-1:0]      sample_two,
	input  logic [lswp_pkg::SAMPLE_BITS-1:0]      sample_three,
	input  logic [lswp_pkg::SAMPLE_BITS-1:0]      sample_four,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [lswp_pkg::POS_BITS-1:0]  line_position,
	output logic [lswp_pkg::TOTAL_BITS-1:0]       total_strength,
	output logic                                  line_seen,
	output logic                                  all_on_line,
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lswp_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [lswp_pkg::DATA_BITS-1:0]        pwdata,
	output logic [lswp_pkg::DATA_BITS-1:0]        prdata,
	output logic                                  pready
);
	localparam int NSTG = 9;
	localparam int PB   = lswp_pkg::POS_BITS;

	lswp_pkg::lswp_cfg_t cfg;
	lswp_pkg::lswp_div_t div_front;
	lswp_pkg::lswp_div_t div_back;

	logic [lswp_pkg::SENSOR_COUNT-1:0][lswp_pkg::SAMPLE_BITS-1:0] smp;

	logic [NSTG-1:0] vld;     // stage valids, s1 at bit 0, output stage at top
	logic [NSTG-1:0] adv;     // stage load enables

	logic signed [PB:0]                pos_full;
	logic signed [PB-1:0]              pos_d;
	logic signed [PB-1:0]              line_position_s9;
	logic [lswp_pkg::TOTAL_BITS-1:0]   total_strength_s9;
	logic                              line_seen_s9;
	logic                              all_on_line_s9;
	logic                              out_valid_s9;

	assign smp = {sample_four, sample_three, sample_two, sample_one, sample_zero};

	lswp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stall chain: a stage loads when empty or when its successor loads.
	always_comb begin
		adv[NSTG-1] = ~out_valid_s9 | out_ready;
		for (int k = NSTG - 2; k >= 0; k--)
			adv[k] = ~vld[k] | adv[k+1];
	end

	assign vld[NSTG-1] = out_valid_s9;
	assign in_ready    = adv[0];

	lswp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.smp      (smp),
		.cfg      (cfg),
		.adv      (adv[3:0]),
		.vld      (vld[3:0]),
		.div_o    (div_front)
	);

	lswp_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld[3]),
		.div_i  (div_front),
		.adv    (adv[7:4]),
		.vld    (vld[7:4]),
		.div_o  (div_back)
	);

	// Apply sign, clamp to the 12-bit range, zero when the line is not seen or the total is zero.
	always_comb begin
		pos_full = div_back.neg ? -$signed({1'b0, div_back.quo})
		                        :  $signed({1'b0, div_back.quo});
		if (!div_back.do_div)
			pos_d = '0;
		else if (pos_full > lswp_pkg::POS_MAX)
			pos_d = PB'(lswp_pkg::POS_MAX);
		else if (pos_full < lswp_pkg::POS_MIN)
			pos_d = PB'(lswp_pkg::POS_MIN);
		else
			pos_d = pos_full[PB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s9 <= 1'b0;
		else if (adv[NSTG-1])
			out_valid_s9 <= vld[NSTG-2];
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			line_position_s9  <= pos_d;
			total_strength_s9 <= div_back.dvs;
			line_seen_s9      <= div_back.seen;
			all_on_line_s9    <= div_back.all_on;
		end
	end

	assign out_valid      = out_valid_s9;
	assign line_position  = line_position_s9;
	assign total_strength = total_strength_s9;
	assign line_seen      = line_seen_s9;
	assign all_on_line    = all_on_line_s9;

	// Input backs up only when the output beat is held.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without an output stall");

	// Every sensor past threshold means every strength is at least one.
	a_all_on_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_on_line) |->
			(total_strength >= lswp_pkg::TOTAL_BITS'(lswp_pkg::SENSOR_COUNT)))
		else $error("all_on_line with too small a total");

	// A result leaving with no stall is replaced by the beat behind it or a bubble.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld[NSTG-2]) |=> !out_valid)
		else $error("output beat repeated");

	// A line not seen always reports position zero.
	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !line_seen) |-> (line_position == '0))
		else $error("position nonzero while line not seen");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the line sensor weighted position unit.
`timescale 1ns / 1ps
module tb_top;
	import lswp_pkg::*;

	localparam int REG_STRIDE  = 8;     // registers are 64 bits wide, so 8-byte spacing
	localparam int PIPE_DEPTH  = 9;     // pipeline stages from input to output, as NSTG in the top level
	localparam int QUIET_LIMIT = 2000;  // cycles without any beat before the run is abandoned
	localparam int LONG_HOLD   = 150;   // receiver hold-off used to back the pipeline up
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

	typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_set_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] position;
		logic [TOTAL_BITS-1:0]      total;
		logic                       seen;
		logic                       all_on;
	} position_result_t;

	// Keeps its own copy of the registers, predicts each position result and
	// checks the results in order.
	class line_position_scoreboard;
		lswp_cfg_t        cfg;
		position_result_t expected_positions[$];
		int               errors;

		function new();
			cfg             = '0;
			cfg.dark_is_low = 1'b1;
			errors          = 0;
		endfunction

		function void set_register(int idx, logic [DATA_BITS-1:0] value);
			case (idx)
				REG_THR: cfg.thr          = value[SENSOR_COUNT*SAMPLE_BITS-1:0];
				REG_WGT: cfg.wgt          = value[SENSOR_COUNT*WEIGHT_BITS-1:0];
				REG_MIN: cfg.min_strength = value[TOTAL_BITS-1:0];
				REG_DRK: cfg.dark_is_low  = value[0];
				default: ;
			endcase
		endfunction

		function position_result_t predict_position(sample_set_t s);
			position_result_t r;
			int               strength;
			int               total;
			longint           wsum;
			longint           pos;
			logic             all_on;
			total  = 0;
			wsum   = 0;
			all_on = 1'b1;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				strength = cfg.dark_is_low ? int'(cfg.thr[i]) - int'(s[i])
				                           : int'(s[i]) - int'(cfg.thr[i]);
				if (strength < 0)
					strength = 0;
				if (strength == 0)
					all_on = 1'b0;
				total += strength;
				wsum  += longint'(strength) * longint'(signed'(cfg.wgt[i]));
			end
			r.seen   = (total >= int'(cfg.min_strength));
			r.all_on = all_on;
			pos      = 0;
			// zero total with zero minimum is seen, but there is nothing to divide
			if (r.seen && total != 0) begin
				pos = wsum / total;          // signed divide truncates toward zero
				if (pos > 2047)
					pos = 2047;
				if (pos < -2048)
					pos = -2048;
			end
			r.position = pos[POS_BITS-1:0];
			r.total    = (total > 8191) ? TOTAL_BITS'(8191) : TOTAL_BITS'(total);
			return r;
		endfunction

		function void note_set(sample_set_t s);
			expected_positions.push_back(predict_position(s));
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task check_position(position_result_t got);
			position_result_t want;
			if (expected_positions.size() == 0) begin
				report($sformatf("result beat with nothing pending (pos %0d total %0d)",
					got.position, got.total));
				return;
			end
			want = expected_positions.pop_front();
			if (got.position !== want.position)
				report($sformatf("line_position got %0d want %0d", got.position, want.position));
			if (got.total !== want.total)
				report($sformatf("total_strength got %0d want %0d", got.total, want.total));
			if (got.seen !== want.seen)
				report($sformatf("line_seen got %b want %b", got.seen, want.seen));
			if (got.all_on !== want.all_on)
				report($sformatf("all_on_line got %b want %b", got.all_on, want.all_on));
		endtask
	endclass

	// DUT-facing signals; every input starts at a known value
	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        in_valid     = 1'b0;
	logic                        in_ready;
	logic [SAMPLE_BITS-1:0]      sample_zero  = '0;
	logic [SAMPLE_BITS-1:0]      sample_one   = '0;
	logic [SAMPLE_BITS-1:0]      sample_two   = '0;
	logic [SAMPLE_BITS-1:0]      sample_three = '0;
	logic [SAMPLE_BITS-1:0]      sample_four  = '0;
	logic                        out_valid;
	logic                        out_ready    = 1'b0;
	logic signed [POS_BITS-1:0]  line_position;
	logic [TOTAL_BITS-1:0]       total_strength;
	logic                        line_seen;
	logic                        all_on_line;
	logic                        psel         = 1'b0;
	logic                        penable      = 1'b0;
	logic                        pwrite       = 1'b0;
	logic [ADDR_BITS-1:0]        paddr        = '0;
	logic [DATA_BITS-1:0]        pwdata       = '0;
	logic [DATA_BITS-1:0]        prdata;
	logic                        pready;

	line_position_scoreboard board;

	// idling controls shared between the sender and the receiver process
	bit          tx_idling;
	bit          rx_idling;
	int unsigned hold_cycles;
	int unsigned quiet_cycles;

	line_sensor_weighted_position_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_zero   (sample_zero),
		.sample_one    (sample_one),
		.sample_two    (sample_two),
		.sample_three  (sample_three),
		.sample_four   (sample_four),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_position (line_position),
		.total_strength(total_strength),
		.line_seen     (line_seen),
		.all_on_line   (all_on_line),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap length: mostly short, now and then a long one.
	function automatic int unsigned gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	// A sample on the line side (past) or the background side of a threshold.
	// Depends on polarity: with dark-low, past means strictly below.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(int thr, bit dark, bit past);
		if (dark) begin
			if (past && thr > 0)
				return SAMPLE_BITS'($urandom_range(thr - 1, 0));
			return past ? '0 : SAMPLE_BITS'($urandom_range(SAMPLE_MAX, thr));
		end
		if (past && thr < SAMPLE_MAX)
			return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, thr + 1));
		return past ? SAMPLE_BITS'(SAMPLE_MAX) : SAMPLE_BITS'($urandom_range(thr, 0));
	endfunction

	function automatic sample_set_t set_of(int s0, int s1, int s2, int s3, int s4);
		sample_set_t s;
		s[0] = SAMPLE_BITS'(s0);
		s[1] = SAMPLE_BITS'(s1);
		s[2] = SAMPLE_BITS'(s2);
		s[3] = SAMPLE_BITS'(s3);
		s[4] = SAMPLE_BITS'(s4);
		return s;
	endfunction

	// Random sample set: per sensor, either a line-like pattern (one or two adjacent
	// sensors on the line) or a value of its own, near, at or far from its threshold.
	function automatic sample_set_t random_set();
		sample_set_t s;
		int          thr;
		int          center;
		int          wide;
		int          v;
		center = $urandom_range(SENSOR_COUNT - 1, 0);
		wide   = $urandom_range(1, 0);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			thr = int'(board.cfg.thr[i]);
			if ($urandom_range(1, 0) == 0) begin
				s[i] = pick_sample(thr, board.cfg.dark_is_low,
					(i == center) || (wide && i == center + 1));
			end else begin
				case ($urandom_range(4, 0))
					0, 1: s[i] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
					2: begin
						v = thr + $urandom_range(6, 0) - 3;
						if (v < 0)
							v = 0;
						if (v > SAMPLE_MAX)
							v = SAMPLE_MAX;
						s[i] = SAMPLE_BITS'(v);
					end
					3: s[i] = SAMPLE_BITS'(thr);
					default: s[i] = $urandom_range(1, 0) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
				endcase
			end
		end
		return s;
	endfunction

	// Offer one sample set and hold it until the beat is taken. Valid is left
	// high so back-to-back beats need no second assignment in one time step.
	task automatic send_set(sample_set_t s);
		in_valid     <= 1'b1;
		sample_zero  <= s[0];
		sample_one   <= s[1];
		sample_two   <= s[2];
		sample_three <= s[3];
		sample_four  <= s[4];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_set(s);
		if (tx_idling && $urandom_range(2, 0) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Stop offering and wait for the pipeline to hand back everything it holds.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup phase, access phase (write lands at its closing edge), then idle.
	task automatic reg_write(int idx, logic [DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(idx * REG_STRIDE);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.set_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [DATA_BITS-1:0] thr, logic [DATA_BITS-1:0] wgt,
	                          int min_strength, bit dark);
		reg_write(REG_THR, thr);
		reg_write(REG_WGT, wgt);
		reg_write(REG_MIN, DATA_BITS'(min_strength));
		reg_write(REG_DRK, DATA_BITS'(dark));
	endtask

	// Random register set; extremes of every field show up regularly.
	task automatic random_config();
		logic [DATA_BITS-1:0] thr;
		logic [DATA_BITS-1:0] wgt;
		int                   min_strength;
		thr = '0;
		wgt = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			case ($urandom_range(3, 0))
				0: thr[i*SAMPLE_BITS +: SAMPLE_BITS] = '0;
				1: thr[i*SAMPLE_BITS +: SAMPLE_BITS] = '1;
				default: thr[i*SAMPLE_BITS +: SAMPLE_BITS] =
					SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
			endcase
			case ($urandom_range(5, 0))
				0: wgt[i*WEIGHT_BITS +: WEIGHT_BITS] = 12'h7FF;
				1: wgt[i*WEIGHT_BITS +: WEIGHT_BITS] = 12'h800;
				default: wgt[i*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom());
			endcase
		end
		case ($urandom_range(4, 0))
			0: min_strength = 0;
			1: min_strength = 5115;
			2: min_strength = $urandom_range(5115, 0);
			default: min_strength = $urandom_range(1500, 0);
		endcase
		set_config(thr, wgt, min_strength, 1'($urandom_range(1, 0)));
	endtask

	// Receiver: ready pattern with random stalls, plus an on-demand long hold-off
	// counted here so the sender keeps pushing into a backed-up pipeline.
	initial begin
		int unsigned n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles != 0) begin
				n           = hold_cycles;
				hold_cycles = 0;
				out_ready  <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (rx_idling && $urandom_range(3, 0) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Result beats are taken at the edge with the values that stood before it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_position('{line_position, total_strength, line_seen, all_on_line});
	end

	// Watchdog: ends a hung run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Main sequence: directed corners, then random phases with varying pressure.
	initial begin
		board       = new();
		tx_idling   = 1'b0;
		rx_idling   = 1'b0;
		hold_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero thresholds, dark-low, zero minimum. Nothing can be
		// past a zero threshold, so the total is zero and still counts as seen.
		send_set(set_of(0, 0, 0, 0, 0));
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		drain();

		// Full thresholds, weights from -2048 to +2047 across the array.
		set_config(DATA_BITS'({5{10'h3FF}}),
			DATA_BITS'({12'sd2047, 12'sd1000, 12'sd0, -12'sd1000, -12'sd2048}), 0, 1'b1);
		send_set(set_of(0, 0, 0, 0, 0));                       // every sensor on the line
		send_set(set_of(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));  // far left
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0));  // far right
		send_set(set_of(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX));  // center, zero weight
		// negative quotient with a remainder: must round toward zero, not down
		send_set(set_of(1020, SAMPLE_MAX, SAMPLE_MAX, 1021, SAMPLE_MAX));
		send_set(set_of(1000, 900, 1022, 512, 1));
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));  // all at thr
		drain();

		// Bright line, zero thresholds, all weights -1, minimum at the top.
		set_config(DATA_BITS'({5{12'hFFF}} & {5{12'hFFF}}), DATA_BITS'({5{12'hFFF}}),
			5115, 1'b0);
		reg_write(REG_THR, '0);
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		send_set(set_of(SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX));  // short of min
		send_set(set_of(0, 0, 0, 0, 0));
		drain();

		// Mixed thresholds, maximum weights, minimum of one; samples just past,
		// at and short of each threshold.
		set_config(DATA_BITS'({10'd1022, 10'd1, 10'd512, 10'd1023, 10'd0}),
			DATA_BITS'({5{12'h7FF}}), 1, 1'b0);
		send_set(set_of(1, SAMPLE_MAX, 513, 2, SAMPLE_MAX));
		send_set(set_of(0, SAMPLE_MAX, 512, 1, 1022));
		send_set(set_of(SAMPLE_MAX, 0, 0, 0, 0));
		drain();
		reg_write(REG_WGT, DATA_BITS'({5{12'h800}}));
		send_set(set_of(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		drain();

		// Random phases, about a hundred beats each, under different pressure.
		for (int phase = 0; phase < 6; phase++) begin
			random_config();
			tx_idling = (phase == 1) || (phase >= 3);
			rx_idling = (phase >= 2);
			if (phase == 2 || phase == 5) begin
				// stall the output long enough to fill every stage while
				// the sender keeps offering back to back
				tx_idling   = 1'b0;
				hold_cycles = LONG_HOLD;
			end
			for (int k = 0; k < 100; k++) begin
				if (k == 40)
					tx_idling = (phase >= 1);
				send_set(random_set());
			end
			drain();
		end

		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
